### sv/grid_disc_visibility_stamper_defines.svh
// Assertion macros for the checker file of the visibility stamper.
`ifndef GRID_DISC_VISIBILITY_STAMPER_DEFINES_SVH
`define GRID_DISC_VISIBILITY_STAMPER_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define GDVS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define GDVS_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/gdvs_pkg.sv
// Types and constants shared by the visibility stamper modules.
package gdvs_pkg;

  localparam int OP_W       = 2;
  localparam int POS_W      = 24;
  localparam int RAD_W      = 20;
  localparam int CS_W       = 16;
  localparam int GRID_W     = 7;
  localparam int QC_W       = 6;
  localparam int CNT_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Magnitude of a position minus an origin needs one bit more than a position.
  localparam int DIV_N_W    = POS_W + 1;
  // Cell radius never exceeds the radius field itself.
  localparam int RCELL_W    = RAD_W;
  localparam int SQ_W       = 2 * RCELL_W + 1;
  localparam int CTR_W      = DIV_N_W + 1;
  localparam int BND_W      = CTR_W + 2;
  localparam int DX_W       = RCELL_W + 2;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_STAMP = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = 3'd4;

  localparam logic [GRID_W-1:0] GRID_DIM_RESET  = 7'd64;
  localparam logic [CS_W-1:0]   CELL_SIZE_RESET = 16'd256;

  typedef struct packed {
    logic [GRID_W-1:0]       grid_width;
    logic [GRID_W-1:0]       grid_height;
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_y;
    logic [CS_W-1:0]         cell_size;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [RAD_W-1:0]        radius;
    logic [QC_W-1:0]         cell_x;
    logic [QC_W-1:0]         cell_y;
  } item_t;

  typedef struct packed {
    logic             visible;
    logic             explored;
    logic [CNT_W-1:0] cells_marked;
  } result_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quo;
    logic [CS_W-1:0]    rem;
  } div_res_t;

endpackage

### sv/gdvs_div.sv
// Restoring divider that produces one quotient bit per cycle.
module gdvs_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [gdvs_pkg::DIV_N_W-1:0] dividend,
  input  logic [gdvs_pkg::CS_W-1:0]    divisor,
  output gdvs_pkg::div_res_t           res
);
  import gdvs_pkg::*;

  localparam int CNT_BITS = $clog2(DIV_N_W + 1);

  logic                busy;
  logic                done;
  logic [CNT_BITS-1:0] count;
  logic [DIV_N_W-1:0]  quo;
  logic [CS_W-1:0]     rem;
  logic [CS_W:0]       shifted;
  logic [CS_W:0]       diff;
  logic                ge;

  always_comb begin
    shifted = {rem, quo[DIV_N_W-1]};
    diff    = shifted - {1'b0, divisor};
    ge      = shifted >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == CNT_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend;
      rem   <= '0;
      count <= CNT_BITS'(DIV_N_W);
    end else if (busy) begin
      quo   <= {quo[DIV_N_W-2:0], ge};
      rem   <= ge ? diff[CS_W-1:0] : shifted[CS_W-1:0];
      count <= count - CNT_BITS'(1);
    end
  end

  assign res = '{done: done, quo: quo, rem: rem};

endmodule

### sv/gdvs_core.sv
// Map memory and the sequencer that stamps discs, clears and queries rows.
module gdvs_core #(
  parameter int MAX_GRID_WIDTH  = 64,
  parameter int MAX_GRID_HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  gdvs_pkg::cfg_t    cfg,
  input  logic              item_valid,
  input  gdvs_pkg::item_t   item,
  output logic              item_ready,
  output logic              res_valid,
  output gdvs_pkg::result_t res,
  input  logic              res_ready
);
  import gdvs_pkg::*;

  localparam int COL_AW = (MAX_GRID_WIDTH > 1) ? $clog2(MAX_GRID_WIDTH) : 1;
  localparam int ROW_AW = (MAX_GRID_HEIGHT > 1) ? $clog2(MAX_GRID_HEIGHT) : 1;
  localparam int WCLIP  = (MAX_GRID_WIDTH > 127) ? 127 : MAX_GRID_WIDTH;
  localparam int HCLIP  = (MAX_GRID_HEIGHT > 127) ? 127 : MAX_GRID_HEIGHT;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_QREAD    = 4'd1;
  localparam logic [3:0] ST_DIV_R    = 4'd2;
  localparam logic [3:0] ST_DIV_X    = 4'd3;
  localparam logic [3:0] ST_DIV_Y    = 4'd4;
  localparam logic [3:0] ST_CLIP     = 4'd5;
  localparam logic [3:0] ST_MUL_R    = 4'd6;
  localparam logic [3:0] ST_MUL_DX   = 4'd7;
  localparam logic [3:0] ST_DX2      = 4'd8;
  localparam logic [3:0] ST_ROW_SQ   = 4'd9;
  localparam logic [3:0] ST_ROW_LOAD = 4'd10;
  localparam logic [3:0] ST_SCAN     = 4'd11;
  localparam logic [3:0] ST_WRITE    = 4'd12;
  localparam logic [3:0] ST_DONE     = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  // Row storage: explored bits in the upper half, visible bits in the lower half.
  logic [2*MAX_GRID_WIDTH-1:0] mem [MAX_GRID_HEIGHT];
  logic [2*MAX_GRID_WIDTH-1:0] rd_data;
  logic                        rd_en;
  logic [ROW_AW-1:0]           rd_addr;
  logic                        wr_en;
  logic [MAX_GRID_WIDTH-1:0]   rd_vis;
  logic [MAX_GRID_WIDTH-1:0]   rd_exp;

  // A row whose flag is low reads as all zeros, which stands in for clearing.
  logic [MAX_GRID_HEIGHT-1:0] vis_ok;
  logic [MAX_GRID_HEIGHT-1:0] exp_ok;
  logic                       clear_vis;

  item_t                     it;
  logic [GRID_W-1:0]         eff_w;
  logic [GRID_W-1:0]         eff_h;
  logic                      q_in_range;
  logic                      div_start;
  logic [DIV_N_W-1:0]        div_num;
  div_res_t                  div_res;
  logic                      neg;
  logic signed [DIV_N_W-1:0] diff_s;
  logic [DIV_N_W-1:0]        diff_mag;
  logic                      rem_nz;
  logic [DIV_N_W-1:0]        q_ceil;
  logic [RCELL_W-1:0]        r_calc;
  logic signed [CTR_W-1:0]   q_ext;
  logic signed [CTR_W-1:0]   floor_q;

  logic [RCELL_W-1:0]      r;
  logic signed [CTR_W-1:0] cx;
  logic signed [CTR_W-1:0] cy;
  logic signed [BND_W-1:0] cx_e;
  logic signed [BND_W-1:0] cy_e;
  logic signed [BND_W-1:0] r_e;
  logic signed [BND_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [BND_W-1:0] minx_b, maxx_b, miny_b, maxy_b;
  logic signed [BND_W-1:0] wm1, hm1;
  logic                    empty;
  logic [COL_AW-1:0]       minx, maxx, x;
  logic [ROW_AW-1:0]       miny, maxy, y;
  logic signed [BND_W-1:0] dx0_full;
  logic signed [BND_W-1:0] dy_full;
  logic signed [DX_W-1:0]  dx0, dx, dy, dx0_mag, dy_mag;

  logic [RCELL_W-1:0]     mul_a;
  logic [2*RCELL_W-1:0]   mul_p;
  logic [SQ_W-1:0]        rsq, dx2, dx2_start, dy2;
  logic [SQ_W:0]          dist_sq;
  logic                   hit;
  logic signed [SQ_W:0]   dx2_step;

  logic [MAX_GRID_WIDTH-1:0] vis_buf;
  logic [MAX_GRID_WIDTH-1:0] exp_buf;
  logic [CNT_W-1:0]          count;
  logic                      res_vis;
  logic                      res_exp;

  always_comb begin
    eff_w = (cfg.grid_width > GRID_W'(WCLIP)) ? GRID_W'(WCLIP) : cfg.grid_width;
    eff_h = (cfg.grid_height > GRID_W'(HCLIP)) ? GRID_W'(HCLIP) : cfg.grid_height;
    q_in_range = ({1'b0, item.cell_x} < eff_w) && ({1'b0, item.cell_y} < eff_h);
  end

  // Position minus origin, for x while the radius divide runs and y after.
  always_comb begin
    if (state == ST_DIV_X) begin
      diff_s = {it.pos_y[POS_W-1], it.pos_y} - {cfg.origin_y[POS_W-1], cfg.origin_y};
    end else begin
      diff_s = {it.pos_x[POS_W-1], it.pos_x} - {cfg.origin_x[POS_W-1], cfg.origin_x};
    end
    diff_mag = diff_s[DIV_N_W-1] ? (~diff_s + 1'b1) : diff_s;
  end

  // Quotient corrections: ceiling (at least one) for the radius, floor for the centre.
  always_comb begin
    rem_nz  = |div_res.rem;
    q_ceil  = div_res.quo + {{(DIV_N_W-1){1'b0}}, rem_nz};
    r_calc  = (q_ceil == '0) ? RCELL_W'(1) : q_ceil[RCELL_W-1:0];
    q_ext   = {1'b0, div_res.quo};
    floor_q = neg ? (-q_ext - {{(CTR_W-1){1'b0}}, rem_nz}) : q_ext;
  end

  // Clip the square around the centre to the grid.
  always_comb begin
    cx_e   = {{(BND_W-CTR_W){cx[CTR_W-1]}}, cx};
    cy_e   = {{(BND_W-CTR_W){cy[CTR_W-1]}}, cy};
    r_e    = {{(BND_W-RCELL_W){1'b0}}, r};
    wm1    = {{(BND_W-GRID_W){1'b0}}, eff_w} - BND_W'(1);
    hm1    = {{(BND_W-GRID_W){1'b0}}, eff_h} - BND_W'(1);
    lo_x   = cx_e - r_e;
    hi_x   = cx_e + r_e;
    lo_y   = cy_e - r_e;
    hi_y   = cy_e + r_e;
    minx_b = (lo_x < 0) ? '0 : lo_x;
    maxx_b = (hi_x > wm1) ? wm1 : hi_x;
    miny_b = (lo_y < 0) ? '0 : lo_y;
    maxy_b = (hi_y > hm1) ? hm1 : hi_y;
    empty  = (minx_b > maxx_b) || (miny_b > maxy_b);
  end

  always_comb begin
    dx0_full = $signed({{(BND_W-COL_AW){1'b0}}, minx}) - cx_e;
    dy_full  = $signed({{(BND_W-ROW_AW){1'b0}}, y}) - cy_e;
    dy       = dy_full[DX_W-1:0];
    dx0_mag  = dx0[DX_W-1] ? (~dx0 + 1'b1) : dx0;
    dy_mag   = dy[DX_W-1] ? (~dy + 1'b1) : dy;
    dist_sq  = {1'b0, dx2} + {1'b0, dy2};
    hit      = dist_sq <= {1'b0, rsq};
    // Next square from the current one: (dx+1)^2 = dx^2 + 2dx + 1.
    dx2_step = $signed({1'b0, dx2}) + {{(SQ_W-DX_W){dx[DX_W-1]}}, dx, 1'b1};
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = diff_mag;
    rd_en      = 1'b0;
    rd_addr    = y;
    wr_en      = 1'b0;
    clear_vis  = 1'b0;
    mul_a      = r;
    case (state)
      ST_IDLE: begin
        div_num = {{(DIV_N_W-RAD_W){1'b0}}, item.radius};
        if (item_valid) begin
          case (item.op)
            OP_CLEAR: begin
              clear_vis  = 1'b1;
              state_next = ST_DONE;
            end
            OP_STAMP: begin
              if (eff_w == '0 || eff_h == '0 || cfg.cell_size == '0) begin
                state_next = ST_DONE;
              end else begin
                div_start  = 1'b1;
                state_next = ST_DIV_R;
              end
            end
            OP_QUERY: begin
              if (q_in_range) begin
                rd_en      = 1'b1;
                rd_addr    = ROW_AW'(item.cell_y);
                state_next = ST_QREAD;
              end else begin
                state_next = ST_DONE;
              end
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_QREAD: state_next = ST_DONE;
      ST_DIV_R: begin
        if (div_res.done) begin
          div_start  = 1'b1;
          state_next = ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        if (div_res.done) begin
          div_start  = 1'b1;
          state_next = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (div_res.done) begin
          state_next = ST_CLIP;
        end
      end
      ST_CLIP:  state_next = empty ? ST_DONE : ST_MUL_R;
      ST_MUL_R: state_next = ST_MUL_DX;
      ST_MUL_DX: begin
        mul_a      = dx0_mag[RCELL_W-1:0];
        state_next = ST_DX2;
      end
      ST_DX2: state_next = ST_ROW_SQ;
      ST_ROW_SQ: begin
        mul_a      = dy_mag[RCELL_W-1:0];
        rd_en      = 1'b1;
        state_next = ST_ROW_LOAD;
      end
      ST_ROW_LOAD: state_next = ST_SCAN;
      ST_SCAN: begin
        if (x == maxx) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        wr_en      = 1'b1;
        state_next = (y == maxy) ? ST_DONE : ST_ROW_SQ;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      vis_ok <= '0;
      exp_ok <= '0;
    end else begin
      state <= state_next;
      if (clear_vis) begin
        vis_ok <= '0;
      end
      if (wr_en) begin
        vis_ok[y] <= 1'b1;
        exp_ok[y] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[y] <= {exp_buf, vis_buf};
    end
  end

  assign rd_vis = rd_data[MAX_GRID_WIDTH-1:0];
  assign rd_exp = rd_data[2*MAX_GRID_WIDTH-1:MAX_GRID_WIDTH];

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_a;
    if (div_start) begin
      neg <= diff_s[DIV_N_W-1];
    end
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          it      <= item;
          res_vis <= 1'b0;
          res_exp <= 1'b0;
          count   <= '0;
        end
      end
      ST_QREAD: begin
        res_vis <= vis_ok[ROW_AW'(it.cell_y)] & rd_vis[COL_AW'(it.cell_x)];
        res_exp <= exp_ok[ROW_AW'(it.cell_y)] & rd_exp[COL_AW'(it.cell_x)];
      end
      ST_DIV_R: begin
        if (div_res.done) begin
          r <= r_calc;
        end
      end
      ST_DIV_X: begin
        if (div_res.done) begin
          cx <= floor_q;
        end
      end
      ST_DIV_Y: begin
        if (div_res.done) begin
          cy <= floor_q;
        end
      end
      ST_CLIP: begin
        minx <= minx_b[COL_AW-1:0];
        maxx <= maxx_b[COL_AW-1:0];
        miny <= miny_b[ROW_AW-1:0];
        maxy <= maxy_b[ROW_AW-1:0];
      end
      ST_MUL_R: begin
        dx0 <= dx0_full[DX_W-1:0];
        y   <= miny;
      end
      ST_MUL_DX: rsq <= {1'b0, mul_p};
      ST_DX2:    dx2_start <= {1'b0, mul_p};
      ST_ROW_LOAD: begin
        dy2     <= {1'b0, mul_p};
        vis_buf <= vis_ok[y] ? rd_vis : '0;
        exp_buf <= exp_ok[y] ? rd_exp : '0;
        x       <= minx;
        dx      <= dx0;
        dx2     <= dx2_start;
      end
      ST_SCAN: begin
        if (hit) begin
          vis_buf[x] <= 1'b1;
          exp_buf[x] <= 1'b1;
          count      <= count + CNT_W'(1);
        end
        x   <= x + COL_AW'(1);
        dx  <= dx + DX_W'(1);
        dx2 <= dx2_step[SQ_W-1:0];
      end
      ST_WRITE: y <= y + ROW_AW'(1);
      default: ;
    endcase
  end

  gdvs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (cfg.cell_size),
    .res      (div_res)
  );

  assign item_ready = (state == ST_IDLE);
  assign res_valid  = (state == ST_DONE);
  assign res        = '{visible: res_vis, explored: res_exp, cells_marked: count};

endmodule

### sv/grid_disc_visibility_stamper.sv
// A clear goes straight to the result and a query first reads the row of its cell.
// A stamp runs three divides on one shared divider, then per row one row read, a scan
// of one cell per cycle across the clipped square and one row write-back.
// One word at a time: the next word is taken as soon as a result leaves the engine.
// Reset clears the per-row valid flags together, so both maps read as zero at once.
// Configuration registers return to a 64 by 64 grid, origin zero and cell size 256.
module grid_disc_visibility_stamper #(
  parameter int MAX_GRID_WIDTH  = 64,
  parameter int MAX_GRID_HEIGHT = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [gdvs_pkg::OP_W-1:0]         op,
  input  logic signed [gdvs_pkg::POS_W-1:0] pos_x,
  input  logic signed [gdvs_pkg::POS_W-1:0] pos_y,
  input  logic [gdvs_pkg::RAD_W-1:0]        radius,
  input  logic [gdvs_pkg::QC_W-1:0]         cell_x,
  input  logic [gdvs_pkg::QC_W-1:0]         cell_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              visible,
  output logic                              explored,
  output logic [gdvs_pkg::CNT_W-1:0]        cells_marked,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gdvs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gdvs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gdvs_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res;
  logic    core_ready;
  logic    res_valid;
  logic    res_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width  <= GRID_DIM_RESET;
      cfg.grid_height <= GRID_DIM_RESET;
      cfg.origin_x    <= '0;
      cfg.origin_y    <= '0;
      cfg.cell_size   <= CELL_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_WIDTH:  cfg.grid_width  <= cfg_data[GRID_W-1:0];
        REG_GRID_HEIGHT: cfg.grid_height <= cfg_data[GRID_W-1:0];
        REG_ORIGIN_X:    cfg.origin_x    <= cfg_data[POS_W-1:0];
        REG_ORIGIN_Y:    cfg.origin_y    <= cfg_data[POS_W-1:0];
        REG_CELL_SIZE:   cfg.cell_size   <= cfg_data[CS_W-1:0];
        default: ;
      endcase
    end
  end

  assign item = '{op: op, pos_x: pos_x, pos_y: pos_y, radius: radius,
                  cell_x: cell_x, cell_y: cell_y};
  assign in_stall = !core_ready;

  gdvs_core #(
    .MAX_GRID_WIDTH  (MAX_GRID_WIDTH),
    .MAX_GRID_HEIGHT (MAX_GRID_HEIGHT)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (in_valid),
    .item       (item),
    .item_ready (core_ready),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  // Output register: the engine hands over its word whenever this slot frees up.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      visible      <= res.visible;
      explored     <= res.explored;
      cells_marked <= res.cells_marked;
    end
  end

endmodule

### sv/gdvs_checker.sv
// Port-level checks for the visibility stamper and their binding.
`include "grid_disc_visibility_stamper_defines.svh"

module gdvs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       visible,
  input logic                       explored,
  input logic [gdvs_pkg::CNT_W-1:0] cells_marked
);

  `GDVS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(visible) && $stable(explored) && $stable(cells_marked),
    "stalled result word changed")

  // Only a stamp sets cells, and a stamp always sets both bits together.
  `GDVS_ASSERT_SAME(a_vis_implies_exp, clk, rst, out_valid && visible, explored,
    "visible cell reported as unexplored")

  `GDVS_ASSERT_SAME(a_fields_exclusive, clk, rst, out_valid && (cells_marked != '0),
    !visible && !explored, "stamp count and query bits in one word")

  `GDVS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall,
    "second word taken while the engine works")

endmodule

bind grid_disc_visibility_stamper gdvs_checker u_gdvs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .visible      (visible),
  .explored     (explored),
  .cells_marked (cells_marked)
);

### bench/tb_top.sv
// Testbench for the grid disc visibility stamper: directed and random words checked by a predictor.
`timescale 1ns / 1ps

module tb_top;
  import gdvs_pkg::*;

  localparam int MAX_W = 64;
  localparam int MAX_H = 64;
  localparam int MAP_CELLS = MAX_W * MAX_H;
  // Slowest legal run: about 1.4k words, each a full-grid stamp plus the longest gaps
  // on both sides, taken about four times over.
  localparam longint CYCLE_LIMIT = 25_000_000;
  localparam longint RAD_MAX = (longint'(1) << RAD_W) - 1;
  localparam longint POS_MAX = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint POS_MIN = -(longint'(1) << (POS_W - 1));
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam cfg_t RESET_CFG = '{GRID_DIM_RESET, GRID_DIM_RESET, '0, '0, CELL_SIZE_RESET};

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [OP_W-1:0]       op;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [RAD_W-1:0]      radius;
  logic [QC_W-1:0]       cell_x;
  logic [QC_W-1:0]       cell_y;
  logic                  out_valid;
  logic                  out_stall;
  logic                  visible;
  logic                  explored;
  logic [CNT_W-1:0]      cells_marked;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cfg_t        grid_cfg;
  bit          lit_map [MAP_CELLS];
  bit          seen_map [MAP_CELLS];
  result_t     owed_results [$];
  int unsigned error_count = 0;
  int unsigned results_seen = 0;
  int unsigned out_hold = 0;
  bit          quiet = 1'b0;

  grid_disc_visibility_stamper #(
    .MAX_GRID_WIDTH(MAX_W),
    .MAX_GRID_HEIGHT(MAX_H)
  ) i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint live_cols();
    return (grid_cfg.grid_width > MAX_W) ? MAX_W : longint'(grid_cfg.grid_width);
  endfunction

  function automatic longint live_rows();
    return (grid_cfg.grid_height > MAX_H) ? MAX_H : longint'(grid_cfg.grid_height);
  endfunction

  function automatic longint floor_div(longint num, longint den);
    longint q;
    q = num / den;
    if (num % den != 0 && num < 0) q -= 1;
    return q;
  endfunction

  function automatic longint stamp_disc(longint px, longint py, longint rad);
    longint cols, rows, cs, rc, cx, cy, x_lo, x_hi, y_lo, y_hi, x, y, dx, dy;
    longint marked = 0;
    cols = live_cols();
    rows = live_rows();
    cs = longint'(grid_cfg.cell_size);
    if (cols == 0 || rows == 0 || cs == 0) return 0;
    rc = (rad + cs - 1) / cs;
    if (rc < 1) rc = 1;
    cx = floor_div(px - longint'($signed(grid_cfg.origin_x)), cs);
    cy = floor_div(py - longint'($signed(grid_cfg.origin_y)), cs);
    x_lo = (cx - rc < 0) ? 0 : cx - rc;
    x_hi = (cx + rc > cols - 1) ? cols - 1 : cx + rc;
    y_lo = (cy - rc < 0) ? 0 : cy - rc;
    y_hi = (cy + rc > rows - 1) ? rows - 1 : cy + rc;
    for (y = y_lo; y <= y_hi; y++) begin
      for (x = x_lo; x <= x_hi; x++) begin
        dx = x - cx;
        dy = y - cy;
        if (dx * dx + dy * dy <= rc * rc) begin
          lit_map[y * MAX_W + x] = 1'b1;
          seen_map[y * MAX_W + x] = 1'b1;
          marked++;
        end
      end
    end
    return marked;
  endfunction

  function automatic result_t visibility_step(item_t word);
    result_t res;
    longint idx;
    res = '0;
    case (word.op)
      OP_CLEAR: lit_map = '{default: 1'b0};
      OP_STAMP: res.cells_marked = CNT_W'(stamp_disc(longint'($signed(word.pos_x)),
                                                     longint'($signed(word.pos_y)),
                                                     longint'(word.radius)));
      OP_QUERY: begin
        if (word.cell_x < live_cols() && word.cell_y < live_rows()) begin
          idx = longint'(word.cell_y) * MAX_W + longint'(word.cell_x);
          res.visible = lit_map[idx];
          res.explored = seen_map[idx];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------- word builders

  function automatic item_t make_word(logic [OP_W-1:0] code);
    item_t word;
    word.op = code;
    word.pos_x = POS_W'($urandom);
    word.pos_y = POS_W'($urandom);
    word.radius = RAD_W'($urandom);
    word.cell_x = QC_W'($urandom);
    word.cell_y = QC_W'($urandom);
    return word;
  endfunction

  function automatic item_t stamp_word(longint px, longint py, longint rad);
    item_t word;
    word = make_word(OP_STAMP);
    word.pos_x = POS_W'(px);
    word.pos_y = POS_W'(py);
    word.radius = RAD_W'(rad);
    return word;
  endfunction

  function automatic item_t query_word(longint qx, longint qy);
    item_t word;
    word = make_word(OP_QUERY);
    word.cell_x = QC_W'(qx);
    word.cell_y = QC_W'(qy);
    return word;
  endfunction

  // Stamp centered on a chosen cell with a chosen cell radius under the current setup.
  function automatic item_t aimed_stamp(longint ccx, longint ccy, longint rc);
    longint cs, px, py, rad;
    cs = longint'(grid_cfg.cell_size);
    if (cs == 0) return make_word(OP_STAMP);
    px = longint'($signed(grid_cfg.origin_x)) + ccx * cs + longint'($urandom_range(0, cs - 1));
    py = longint'($signed(grid_cfg.origin_y)) + ccy * cs + longint'($urandom_range(0, cs - 1));
    rad = (rc == 0) ? 0 : rc * cs - longint'($urandom_range(0, cs - 1));
    if (rad > RAD_MAX) rad = RAD_MAX;
    return stamp_word(px, py, rad);
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_word(input item_t word);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= word.op;
    pos_x <= word.pos_x;
    pos_y <= word.pos_y;
    radius <= word.radius;
    cell_x <= word.cell_x;
    cell_y <= word.cell_y;
    do @(posedge clk); while (in_stall);
    owed_results.push_back(visibility_step(word));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GRID_WIDTH:  grid_cfg.grid_width = data[GRID_W-1:0];
      REG_GRID_HEIGHT: grid_cfg.grid_height = data[GRID_W-1:0];
      REG_ORIGIN_X:    grid_cfg.origin_x = data[POS_W-1:0];
      REG_ORIGIN_Y:    grid_cfg.origin_y = data[POS_W-1:0];
      REG_CELL_SIZE:   grid_cfg.cell_size = data[CS_W-1:0];
      default: ;
    endcase
  endtask

  // Writes every register; when asked, junk fills the unused high bits, and the unmapped
  // indexes get random data.
  task automatic program_grid(input cfg_t c, input bit junk_bits, input bit unmapped);
    logic [CFG_DATA_W-1:0] junk;
    int k;
    wait_idle();
    junk = junk_bits ? CFG_DATA_W'($urandom) : '0;
    write_reg(REG_GRID_WIDTH, {junk[CFG_DATA_W-1:GRID_W], c.grid_width});
    write_reg(REG_GRID_HEIGHT, {junk[CFG_DATA_W-1:GRID_W], c.grid_height});
    write_reg(REG_ORIGIN_X, c.origin_x);
    write_reg(REG_ORIGIN_Y, c.origin_y);
    write_reg(REG_CELL_SIZE, {junk[CFG_DATA_W-1:CS_W], c.cell_size});
    if (unmapped) begin
      for (k = int'(REG_CELL_SIZE) + 1; k < (1 << CFG_IDX_W); k++) begin
        write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- result check

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: result %0d %s: got %0d, want %0d", $time, results_seen, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        report_mismatch("arrived with nothing owed", cells_marked, 0);
      end else begin
        want = owed_results.pop_front();
        if (visible !== want.visible) report_mismatch("visible", visible, want.visible);
        if (explored !== want.explored) report_mismatch("explored", explored, want.explored);
        if (cells_marked !== want.cells_marked)
          report_mismatch("cells_marked", cells_marked, want.cells_marked);
      end
      results_seen++;
      out_hold = quiet ? 0 : $urandom_range(0, 3);
      out_stall <= (out_hold != 0);
    end else if (!rst && out_valid && out_hold != 0) begin
      out_hold = out_hold - 1;
      out_stall <= (out_hold != 0);
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed_ops();
    send_word(query_word(0, 0));
    send_word(query_word(63, 63));
    send_word(stamp_word(10 * 256 + 128, 10 * 256 + 128, 0));
    send_word(query_word(10, 10));
    send_word(query_word(11, 11));
    send_word(stamp_word(32 * 256, 32 * 256, RAD_MAX));
    send_word(make_word(OP_CLEAR));
    send_word(query_word(5, 5));
    send_word(stamp_word(POS_MIN, POS_MAX, 512));
    send_word(stamp_word(POS_MIN, POS_MIN, RAD_MAX));
    send_word(stamp_word(POS_MAX, 0, RAD_MAX));
    // Just below the origin the center must round down to cell -1.
    send_word(stamp_word(-1, -1, 256));
    send_word(stamp_word(0, 0, 257));
    send_word(stamp_word(63 * 256 + 255, 63 * 256 + 255, 512));
    send_word(query_word(1, 1));
    send_word(query_word(2, 2));
    send_word(make_word(OP_UNUSED));
    send_word(query_word(0, 63));
    wait_idle();
  endtask

  task automatic test_config_cases();
    cfg_t c;
    c = RESET_CFG;
    c.grid_width = '0;
    program_grid(c, 1'b0, 1'b0);
    send_word(aimed_stamp(5, 5, 3));
    send_word(query_word(0, 0));
    c.grid_width = GRID_DIM_RESET;
    c.grid_height = '0;
    program_grid(c, 1'b0, 1'b0);
    send_word(aimed_stamp(5, 5, 3));
    send_word(query_word(0, 0));
    c.grid_height = GRID_DIM_RESET;
    c.cell_size = '0;
    program_grid(c, 1'b0, 1'b0);
    send_word(stamp_word(1000, 1000, 5000));
    send_word(query_word(3, 3));

    // Oversized grid dimensions clamp; unit cells and extreme origins.
    c = '{7'd127, 7'd100, POS_W'(POS_MIN), POS_W'(POS_MAX), 16'd1};
    program_grid(c, 1'b1, 1'b1);
    send_word(aimed_stamp(40, 40, 5));
    send_word(aimed_stamp(0, 63, 30));
    send_word(stamp_word(0, 0, RAD_MAX));
    send_word(query_word(63, 63));
    send_word(query_word(40, 40));

    // Cells beyond a shrunk grid keep their bits until it grows back.
    program_grid(RESET_CFG, 1'b0, 1'b0);
    send_word(make_word(OP_CLEAR));
    send_word(aimed_stamp(20, 20, 1));
    c = RESET_CFG;
    c.grid_width = 7'd8;
    c.grid_height = 7'd8;
    program_grid(c, 1'b0, 1'b0);
    send_word(query_word(20, 20));
    send_word(aimed_stamp(20, 20, 2));
    send_word(aimed_stamp(3, 3, 10));
    send_word(query_word(7, 7));
    program_grid(RESET_CFG, 1'b0, 1'b0);
    send_word(query_word(20, 20));
    send_word(query_word(8, 8));

    c = RESET_CFG;
    c.cell_size = 16'hFFFF;
    program_grid(c, 1'b1, 1'b0);
    send_word(stamp_word(0, 0, RAD_MAX));
    send_word(aimed_stamp(30, 2, 3));
    send_word(query_word(17, 0));
    wait_idle();
  endtask

  function automatic logic [GRID_W-1:0] pick_dim();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick < 4) return GRID_W'($urandom_range(MAX_W + 1, (1 << GRID_W) - 1));
    return GRID_W'($urandom_range(1, MAX_W));
  endfunction

  task automatic test_random_traffic();
    cfg_t c;
    int phase, n;
    int unsigned pick;
    longint cols, rows, rc;
    for (phase = 0; phase < 8; phase++) begin
      c = RESET_CFG;
      if (phase != 0) begin
        c.grid_width = pick_dim();
        c.grid_height = pick_dim();
        c.origin_x = ($urandom_range(0, 9) < 3) ? POS_W'($urandom)
                                                : POS_W'(longint'($urandom_range(0, 8192)) - 4096);
        c.origin_y = ($urandom_range(0, 9) < 3) ? POS_W'($urandom)
                                                : POS_W'(longint'($urandom_range(0, 8192)) - 4096);
        pick = $urandom_range(0, 9);
        if (pick == 0) c.cell_size = 16'd1;
        else if (pick == 1) c.cell_size = 16'hFFFF;
        else if (pick == 2) c.cell_size = CS_W'($urandom_range(1, 16'hFFFF));
        else c.cell_size = CS_W'($urandom_range(32, 1024));
      end
      program_grid(c, phase % 3 == 0, phase % 4 == 1);
      quiet = (phase % 3 == 2);
      cols = live_cols();
      rows = live_rows();
      for (n = 0; n < 150; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          send_word(make_word(OP_CLEAR));
        end else if (pick < 45) begin
          // Mostly small discs keep stamps short; a few cover the whole grid.
          pick = $urandom_range(0, 99);
          if (pick < 85) rc = $urandom_range(0, 3);
          else if (pick < 95) rc = $urandom_range(4, 12);
          else rc = $urandom_range(20, 3000);
          send_word(aimed_stamp(longint'($urandom_range(0, cols + 5)) - 3,
                                longint'($urandom_range(0, rows + 5)) - 3, rc));
        end else if (pick < 90) begin
          send_word(query_word($urandom_range(0, (cols + 2 > 63) ? 63 : cols + 2),
                               $urandom_range(0, (rows + 2 > 63) ? 63 : rows + 2)));
        end else if (pick < 94) begin
          send_word(make_word(OP_UNUSED));
        end else begin
          send_word(make_word(OP_W'($urandom_range(0, 3))));
        end
      end
      wait_idle();
    end
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    op <= '0;
    pos_x <= '0;
    pos_y <= '0;
    radius <= '0;
    cell_x <= '0;
    cell_y <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    grid_cfg = RESET_CFG;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_config_cases();
    test_random_traffic();
    wait_idle();
    // Any stray word from the block shows up within this window.
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("grid_disc_visibility_stamper: match");
    end else begin
      $display("grid_disc_visibility_stamper: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    longint cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("grid_disc_visibility_stamper: mismatch");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/gdvs_pkg.sv
sv/gdvs_div.sv
sv/gdvs_core.sv
sv/grid_disc_visibility_stamper.sv
sv/gdvs_checker.sv
bench/tb_top.sv
